FILE: hdl/mtls_pkg.sv
// package for the markov transition learner sampler: types, constants, prior table
`timescale 1ns / 1ps
package mtls_pkg;

    localparam int COUNT_WIDTH_DEF = 16;
    localparam int NSTATES         = 17;
    localparam int NCELLS          = NSTATES * NSTATES;
    localparam int ADDR_W          = 9;
    localparam int STATE_W         = 5;
    localparam logic [4:0] STARTUP_STATE = 5'd16;
    localparam logic [15:0] DEFAULT_LUX  = 16'd200;
    localparam int CFG_W           = 32;

    localparam logic [1:0] CFG_IDLE     = 2'd0;
    localparam logic [1:0] CFG_COOLDOWN = 2'd1;
    localparam logic [1:0] CFG_BASE     = 2'd2;

    localparam logic [1:0] OP_EVENT = 2'd0;
    localparam logic [1:0] OP_LUX   = 2'd1;
    localparam logic [1:0] OP_TICK  = 2'd2;
    localparam logic [1:0] OP_SEED  = 2'd3;

    typedef struct packed {
        logic [1:0]  op;
        logic [2:0]  detection_kind;
        logic [15:0] lux_value;
        logic        lux_valid;
        logic [23:0] random_value;
    } t_in_item;

    typedef struct packed {
        logic [4:0]        state_now;
        logic [4:0]        state_drawn;
        logic              sampled;
        logic              call_fired;
        logic [1:0]        call_kind;
        logic [1:0]        call_band;
        logic signed [3:0] lux_bias_quarters;
    } t_out_item;

    function automatic logic [1:0] band_of(input logic [15:0] lux);
        if (lux < 16'd10) return 2'd0;
        if (lux < 16'd100) return 2'd1;
        if (lux < 16'd500) return 2'd2;
        return 2'd3;
    endfunction

    // prior weight added to cell (from, to)
    function automatic logic [3:0] prior_of(input logic [4:0] fr, input logic [4:0] to);
        logic [9:0] k;
        k = {fr, to};
        unique case (k)
            {5'd16, 5'd1}:  return 4'd8;
            {5'd16, 5'd2}:  return 4'd4;
            {5'd0, 5'd0}:   return 4'd12;
            {5'd0, 5'd8}:   return 4'd3;
            {5'd1, 5'd5}:   return 4'd6;
            {5'd1, 5'd9}:   return 4'd5;
            {5'd2, 5'd6}:   return 4'd5;
            {5'd2, 5'd10}:  return 4'd5;
            {5'd3, 5'd7}:   return 4'd8;
            {5'd3, 5'd15}:  return 4'd6;
            {5'd5, 5'd5}:   return 4'd5;
            {5'd5, 5'd1}:   return 4'd4;
            {5'd6, 5'd6}:   return 4'd4;
            {5'd6, 5'd14}:  return 4'd3;
            {5'd7, 5'd7}:   return 4'd6;
            {5'd7, 5'd15}:  return 4'd5;
            {5'd4, 5'd0}:   return 4'd6;
            {5'd8, 5'd0}:   return 4'd8;
            {5'd9, 5'd1}:   return 4'd6;
            {5'd9, 5'd5}:   return 4'd4;
            {5'd10, 5'd2}:  return 4'd5;
            {5'd11, 5'd7}:  return 4'd5;
            {5'd11, 5'd15}: return 4'd3;
            {5'd12, 5'd0}:  return 4'd10;
            {5'd13, 5'd5}:  return 4'd5;
            {5'd13, 5'd1}:  return 4'd4;
            {5'd14, 5'd14}: return 4'd4;
            {5'd14, 5'd6}:  return 4'd4;
            {5'd15, 5'd15}: return 4'd7;
            default:        return 4'd0;
        endcase
    endfunction

endpackage

FILE: hdl/mtls_count_ram.sv
// transition count memory, one write and one registered read port
`timescale 1ns / 1ps
module mtls_count_ram
    import mtls_pkg::*;
#(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_we,
    input  logic [ADDR_W-1:0]      i_waddr,
    input  logic [COUNT_WIDTH-1:0] i_wdata,
    input  logic [ADDR_W-1:0]      i_raddr,
    output logic [COUNT_WIDTH-1:0] o_rdata
);
    logic [COUNT_WIDTH-1:0] r_mem [NCELLS];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

FILE: hdl/markov_transition_learner_sampler_unit.sv
// top level of the markov transition learner sampler
`timescale 1ns / 1ps
// One item at a time. Lux updates, plain ticks and reset-to-priors items go straight to
// the result, an event reads and rewrites one count cell, and a sampling tick does a pass
// for the row sum, a multiply, a cumulative walk through the single count memory read
// port, then, if a call fires, the follow-up event. After reset and after the result of
// a reset-to-priors item the 289 cells are reseeded, one per cycle, while no item is
// taken. A result waits in the output register; while it waits and the receiver stalls,
// no new item is taken.
module markov_transition_learner_sampler_unit
    import mtls_pkg::*;
#(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    input  t_in_item         i_data,
    output logic             o_valid,
    input  logic             i_stall,
    output t_out_item        o_data,
    input  logic             i_cfg_we,
    input  logic [1:0]       i_cfg_index,
    input  logic [CFG_W-1:0] i_cfg_data
);
    localparam int SUM_W = COUNT_WIDTH + 5;
    localparam logic [COUNT_WIDTH-1:0] CMAX = {COUNT_WIDTH{1'b1}};

    typedef enum logic [8:0] {
        S_SEED  = 9'b000000001,
        S_IDLE  = 9'b000000010,
        S_EVRD  = 9'b000000100,
        S_EVWT  = 9'b000001000,
        S_EVWR  = 9'b000010000,
        S_SUM   = 9'b000100000,
        S_MUL   = 9'b001000000,
        S_WALK  = 9'b010000000,
        S_OUT   = 9'b100000000
    } t_state;

    t_state r_st, n_st;
    logic [31:0] r_idle, r_cool;
    logic [7:0]  r_base;
    logic [4:0]  r_chain, n_chain;
    logic [15:0] r_lux, n_lux;
    logic        r_lux_v, n_lux_v;
    logic [31:0] r_mse, r_msp, n_mse, n_msp;
    t_in_item    r_item, n_item;
    logic [ADDR_W-1:0] r_addr, n_addr;   // seed counter
    logic [4:0]  r_sfr, r_sto, n_sfr, n_sto;   // row and column of the seed counter
    logic [4:0]  r_j, r_jr, n_j, n_jr;   // issued column, column of data arriving
    logic        r_rv, n_rv;             // read data valid
    logic [SUM_W-1:0] r_acc, r_sum, n_acc, n_sum;
    logic [SUM_W+23:0] r_lhs, n_lhs;
    logic [4:0]  r_pred, r_to, n_pred, n_to;
    logic        r_smp, r_fire, n_smp, n_fire;
    logic        r_ov, n_ov;
    t_out_item   r_od;

    logic              we;
    logic [ADDR_W-1:0] waddr, raddr;
    logic [COUNT_WIDTH-1:0] wdata, rdata;

    mtls_count_ram #(.COUNT_WIDTH(COUNT_WIDTH)) u_ram (
        .i_clk(i_clk), .i_we(we), .i_waddr(waddr), .i_wdata(wdata),
        .i_raddr(raddr), .o_rdata(rdata)
    );

    function automatic logic [ADDR_W-1:0] cell_addr(input logic [4:0] fr,
                                                    input logic [4:0] to);
        logic [ADDR_W+4:0] p;
        p = (ADDR_W+5)'(fr) * (ADDR_W+5)'(NSTATES) + (ADDR_W+5)'(to);
        return p[ADDR_W-1:0];
    endfunction

    // seed value for the sweep counter
    logic [COUNT_WIDTH+1:0] sd_v;
    always_comb begin
        sd_v = (COUNT_WIDTH+2)'(r_base) + (COUNT_WIDTH+2)'(prior_of(r_sfr, r_sto));
    end

    logic [1:0] ev_band;
    logic [1:0] ev_kind;
    logic [15:0] ev_lux;
    always_comb begin
        ev_lux = r_lux_v ? r_lux : DEFAULT_LUX;
        if (r_item.op == OP_EVENT && r_item.lux_valid) ev_lux = r_item.lux_value;
        ev_band = band_of(ev_lux);
        if (r_item.op == OP_EVENT) begin
            ev_kind = (r_item.detection_kind >= 3'd1 && r_item.detection_kind <= 3'd3)
                      ? r_item.detection_kind[1:0] : 2'd0;
        end else begin
            ev_kind = r_pred[3:2];
        end
    end

    logic [SUM_W+23:0] cum_sh;
    logic [SUM_W-1:0]  acc_nx;
    logic [31:0]       mse_inc, msp_inc;
    always_comb begin
        acc_nx = r_acc + SUM_W'(rdata);
        cum_sh = {acc_nx, 24'd0};
        mse_inc = (r_mse == '1) ? r_mse : r_mse + 32'd1;
        msp_inc = (r_msp == '1) ? r_msp : r_msp + 32'd1;
    end

    logic take;
    assign o_stall = (r_st != S_IDLE) || (r_ov && i_stall);
    assign take = i_valid && !o_stall;

    always_comb begin
        we = 1'b0;
        waddr = cell_addr(r_chain, r_to);
        wdata = (rdata == CMAX) ? rdata : rdata + COUNT_WIDTH'(1);
        raddr = cell_addr(r_chain, r_j);
        n_st = r_st;
        n_addr = r_addr;
        n_sfr = r_sfr;
        n_sto = r_sto;
        n_chain = r_chain;
        n_lux = r_lux;
        n_lux_v = r_lux_v;
        n_mse = r_mse;
        n_msp = r_msp;
        n_item = r_item;
        n_j = r_j;
        n_jr = r_jr;
        n_rv = 1'b0;
        n_acc = r_acc;
        n_sum = r_sum;
        n_lhs = r_lhs;
        n_pred = r_pred;
        n_to = r_to;
        n_smp = r_smp;
        n_fire = r_fire;
        n_ov = r_ov && i_stall;
        unique case (r_st)
            S_SEED: begin
                we = 1'b1;
                waddr = r_addr;
                wdata = (sd_v > (COUNT_WIDTH+2)'(CMAX)) ? CMAX : sd_v[COUNT_WIDTH-1:0];
                n_addr = r_addr + ADDR_W'(1);
                if (r_sto == 5'd16) begin
                    n_sto = '0;
                    n_sfr = r_sfr + 5'd1;
                end else begin
                    n_sto = r_sto + 5'd1;
                end
                if (r_addr == ADDR_W'(NCELLS - 1)) n_st = S_IDLE;
            end
            S_IDLE: if (take) begin
                n_item = i_data;
                n_smp = 1'b0;
                n_fire = 1'b0;
                n_pred = '0;
                unique case (i_data.op)
                    OP_EVENT: n_st = S_EVRD;
                    OP_LUX: begin
                        n_lux = i_data.lux_valid ? i_data.lux_value : 16'd0;
                        n_lux_v = i_data.lux_valid;
                        if (r_chain < 5'd4)
                            n_chain = {3'd0, i_data.lux_valid
                                       ? band_of(i_data.lux_value) : 2'd0};
                        n_st = S_OUT;
                    end
                    OP_TICK: begin
                        n_mse = mse_inc;
                        n_msp = msp_inc;
                        if (mse_inc >= r_idle && msp_inc >= r_cool) begin
                            n_msp = '0;
                            n_j = '0;
                            n_acc = '0;
                            n_st = S_SUM;
                        end else begin
                            n_st = S_OUT;
                        end
                    end
                    OP_SEED: begin
                        n_chain = STARTUP_STATE;
                        n_st = S_OUT;
                    end
                    default: n_st = S_OUT;
                endcase
            end
            S_EVRD: begin
                raddr = cell_addr(r_chain, {ev_kind, ev_band});
                n_to = {ev_kind, ev_band};
                n_st = S_EVWT;
            end
            S_EVWT: begin
                raddr = cell_addr(r_chain, r_to);
                n_st = S_EVWR;
            end
            S_EVWR: begin
                we = 1'b1;
                n_chain = r_to;
                n_mse = '0;
                n_st = S_OUT;
            end
            S_SUM: begin
                if (r_j != 5'd17) begin
                    n_j = r_j + 5'd1;
                    n_rv = 1'b1;
                    n_jr = r_j;
                end
                if (r_rv) begin
                    n_acc = acc_nx;
                    n_sum = acc_nx;
                    if (r_jr == 5'd16) n_st = S_MUL;
                end
            end
            S_MUL: begin
                n_lhs = (SUM_W+24)'(r_item.random_value) * (SUM_W+24)'(r_sum);
                n_j = '0;
                n_acc = '0;
                n_st = S_WALK;
            end
            S_WALK: begin
                if (r_j != 5'd17) begin
                    n_j = r_j + 5'd1;
                    n_rv = 1'b1;
                    n_jr = r_j;
                end
                if (r_rv) begin
                    n_acc = acc_nx;
                    if (r_lhs < cum_sh || r_jr == 5'd16) begin
                        n_smp = 1'b1;
                        n_pred = (r_lhs < cum_sh) ? r_jr : STARTUP_STATE;
                        // only sound states fire a call
                        if (r_lhs < cum_sh && !r_jr[4] && r_jr[3:2] != 2'd0) begin
                            n_fire = 1'b1;
                            n_st = S_EVRD;
                        end else begin
                            n_st = S_OUT;
                        end
                    end
                end
            end
            S_OUT: begin
                n_ov = 1'b1;
                if (r_item.op == OP_SEED) begin
                    n_addr = '0;
                    n_sfr = '0;
                    n_sto = '0;
                    n_st = S_SEED;
                end else begin
                    n_st = S_IDLE;
                end
            end
            default: n_st = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_SEED;
            r_addr <= '0;
            r_sfr <= '0;
            r_sto <= '0;
            r_idle <= 32'd30000;
            r_cool <= 32'd45000;
            r_base <= 8'd1;
            r_chain <= STARTUP_STATE;
            r_lux <= '0;
            r_lux_v <= 1'b0;
            r_mse <= '0;
            r_msp <= '0;
            r_ov <= 1'b0;
            r_rv <= 1'b0;
        end else begin
            r_st <= n_st;
            r_addr <= n_addr;
            r_sfr <= n_sfr;
            r_sto <= n_sto;
            r_chain <= n_chain;
            r_lux <= n_lux;
            r_lux_v <= n_lux_v;
            r_mse <= n_mse;
            r_msp <= n_msp;
            r_ov <= n_ov;
            r_rv <= n_rv;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_IDLE:     r_idle <= i_cfg_data;
                    CFG_COOLDOWN: r_cool <= i_cfg_data;
                    CFG_BASE:     r_base <= i_cfg_data[7:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_item <= n_item;
        r_j <= n_j;
        r_jr <= n_jr;
        r_acc <= n_acc;
        r_sum <= n_sum;
        r_lhs <= n_lhs;
        r_pred <= n_pred;
        r_to <= n_to;
        r_smp <= n_smp;
        r_fire <= n_fire;
    end

    // result assembly
    always_ff @(posedge i_clk) begin
        if (r_st == S_OUT) begin
            r_od.state_now <= r_chain;
            r_od.state_drawn <= r_pred;
            r_od.sampled <= r_smp;
            r_od.call_fired <= r_fire;
            r_od.call_kind <= r_fire ? r_pred[3:2] : 2'd0;
            r_od.call_band <= r_fire ? r_pred[1:0] : 2'd0;
            if (r_chain[4] || r_chain[3:2] < 2'd2) r_od.lux_bias_quarters <= 4'sd0;
            else if (r_chain[3:2] == 2'd2)
                r_od.lux_bias_quarters <= -$signed({2'b00, r_chain[1:0]}) - 4'sd1;
            else r_od.lux_bias_quarters <= $signed({2'b00, r_chain[1:0]}) + 4'sd1;
        end
    end

    assign o_valid = r_ov;
    assign o_data = r_od;

    a_no_take_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st != S_IDLE) |-> o_stall) else $error("item taken while busy");
    a_chain_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_chain <= STARTUP_STATE) else $error("chain state out of range");
    a_fire_smp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_data.call_fired) |-> o_data.sampled) else $error("call without sample");
endmodule
